// ===== rtl/json_string_unescape_utf8_defines.svh =====
// Shared assertion forms for the string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Same-cycle implication, off during reset.
`define JSU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jsu assertion failed");

// Next-cycle implication, off during reset.
`define JSU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jsu assertion failed");

`endif

// ===== rtl/jsu_pkg.sv =====
`default_nettype none
package jsu_pkg;

  localparam int RUN_MAX = 6;

  typedef enum logic [2:0] {
    M_PLAIN    = 3'd0,
    M_ESC      = 3'd1,
    M_HEX      = 3'd2,
    M_HIGH     = 3'd3,
    M_HIGH_ESC = 3'd4,
    M_HEX2     = 3'd5
  } mode_t;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd1;
  localparam logic [2:0] ERR_TRUNC_ESC   = 3'd2;
  localparam logic [2:0] ERR_UNKNOWN_ESC = 3'd3;
  localparam logic [2:0] ERR_TRUNC_UNI   = 3'd4;
  localparam logic [2:0] ERR_BAD_HEX     = 3'd5;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] acc;
    logic [1:0]  digits;
    logic [9:0]  high;
    logic        held;
  } state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       source_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       string_done;
    logic [2:0] error_code;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       has;
    logic       done;
    logic [2:0] err;
  } entry_t;

  typedef entry_t [RUN_MAX-1:0] ent_list_t;

  typedef struct packed {
    ent_list_t  ent;
    logic [2:0] n;
    logic       closes;
  } run_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } utf8_t;

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.b[0] = {1'b0, cp[6:0]};
      r.len  = 3'd1;
    end else if (cp < 21'h800) begin
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
      r.len  = 3'd2;
    end else if (cp < 21'h10000) begin
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
      r.len  = 3'd3;
    end else begin
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
      r.len  = 3'd4;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/jsu_stream_if.sv =====
`default_nettype none
interface jsu_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/jsu_decode.sv =====
`default_nettype none
module jsu_decode (
  input  jsu_pkg::state_t st,
  input  logic [7:0]      in_byte,
  input  logic            source_end,
  output jsu_pkg::state_t st_next,
  output jsu_pkg::run_t   run
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef enum logic [1:0] {K_NONE, K_BYTE, K_DONE, K_CP} kind_t;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction

  state_t      nx;
  kind_t       kind;
  logic [2:0]  err;
  logic [7:0]  sval;
  logic [20:0] cp;
  logic        flush;
  logic        do_fresh;
  logic [15:0] fresh_val;
  logic [4:0]  dig;
  logic [15:0] acc_sh;
  logic [1:0]  cnt_sh;
  logic        esc_hit;
  logic [7:0]  esc_val;
  logic        emit_fl;
  utf8_t       fl;
  utf8_t       mn;
  entry_t [3:0] m;
  logic [2:0]  main_n;
  ent_list_t   ent;

  assign dig    = hex_value(in_byte);
  assign acc_sh = {st.acc[11:0], dig[3:0]};
  assign cnt_sh = st.digits + 2'd1;

  always_comb begin
    esc_hit = 1'b1;
    esc_val = in_byte;
    case (in_byte)
      8'h22, 8'h5C, 8'h2F: esc_val = in_byte;
      8'h6E: esc_val = 8'h0A;
      8'h74: esc_val = 8'h09;
      8'h72: esc_val = 8'h0D;
      8'h62: esc_val = 8'h08;
      8'h66: esc_val = 8'h0C;
      default: esc_hit = 1'b0;
    endcase
  end

  always_comb begin
    nx        = st;
    kind      = K_NONE;
    err       = ERR_NONE;
    sval      = '0;
    cp        = '0;
    flush     = 1'b0;
    do_fresh  = 1'b0;
    fresh_val = acc_sh;
    if (source_end) begin
      kind = K_DONE;
      case (st.mode)
        M_ESC: err = ERR_TRUNC_ESC;
        M_HEX, M_HEX2: err = ERR_TRUNC_UNI;
        M_HIGH: begin
          flush = 1'b1;
          err   = ERR_UNTERMINATED;
        end
        M_HIGH_ESC: begin
          flush = 1'b1;
          err   = ERR_TRUNC_ESC;
        end
        default: err = ERR_UNTERMINATED;
      endcase
    end else begin
      case (st.mode)
        M_ESC, M_HIGH_ESC: begin
          if (st.mode == M_HIGH_ESC && in_byte == CH_U) begin
            nx.mode   = M_HEX2;
            nx.acc    = '0;
            nx.digits = '0;
          end else begin
            if (st.mode == M_HIGH_ESC) begin
              flush   = 1'b1;
              nx.held = 1'b0;
              nx.high = '0;
            end
            if (esc_hit) begin
              nx.mode = M_PLAIN;
              kind    = K_BYTE;
              sval    = esc_val;
            end else if (in_byte == CH_U) begin
              nx.mode   = M_HEX;
              nx.acc    = '0;
              nx.digits = '0;
            end else begin
              kind = K_DONE;
              err  = ERR_UNKNOWN_ESC;
            end
          end
        end
        M_HEX, M_HEX2: begin
          if (dig[4]) begin
            kind = K_DONE;
            err  = ERR_BAD_HEX;
          end else begin
            nx.acc    = acc_sh;
            nx.digits = cnt_sh;
            if (cnt_sh == 2'd0) begin
              nx.acc = '0;
              if (st.mode == M_HEX) begin
                do_fresh = 1'b1;
              end else if (acc_sh[15:10] == 6'b110111) begin
                nx.held = 1'b0;
                nx.high = '0;
                nx.mode = M_PLAIN;
                kind    = K_CP;
                cp      = 21'h10000 + {1'b0, st.high, acc_sh[9:0]};
              end else begin
                flush    = 1'b1;
                nx.held  = 1'b0;
                nx.high  = '0;
                do_fresh = 1'b1;
              end
            end
          end
        end
        default: begin
          if (st.mode == M_HIGH && in_byte == CH_BSLASH) begin
            nx.mode = M_HIGH_ESC;
          end else begin
            if (st.mode == M_HIGH) begin
              flush   = 1'b1;
              nx.held = 1'b0;
              nx.high = '0;
            end
            if (in_byte == CH_QUOTE) begin
              kind = K_DONE;
              err  = ERR_NONE;
            end else if (in_byte == CH_BSLASH) begin
              nx.mode = M_ESC;
            end else begin
              nx.mode = M_PLAIN;
              kind    = K_BYTE;
              sval    = in_byte;
            end
          end
        end
      endcase
    end
    if (do_fresh) begin
      if (fresh_val[15:10] == 6'b110110) begin
        nx.high = fresh_val[9:0];
        nx.held = 1'b1;
        nx.mode = M_HIGH;
      end else begin
        nx.mode = M_PLAIN;
        kind    = K_CP;
        cp      = {5'b0, fresh_val};
      end
    end
    if (kind == K_DONE) nx = '0;
  end

  assign emit_fl = flush && st.held;
  assign fl      = utf8_encode({5'b0, 6'b110110, st.high});
  assign mn      = utf8_encode(cp);

  always_comb begin
    m      = '0;
    main_n = '0;
    case (kind)
      K_BYTE: begin
        m[0]   = '{value: sval, has: 1'b1, done: 1'b0, err: ERR_NONE};
        main_n = 3'd1;
      end
      K_DONE: begin
        m[0]   = '{value: 8'h00, has: 1'b0, done: 1'b1, err: err};
        main_n = 3'd1;
      end
      K_CP: begin
        m[0] = '{value: mn.b[0], has: 1'b1, done: 1'b0, err: ERR_NONE};
        if (mn.len > 3'd1) m[1] = '{value: mn.b[1], has: 1'b1, done: 1'b0, err: ERR_NONE};
        if (mn.len > 3'd2) m[2] = '{value: mn.b[2], has: 1'b1, done: 1'b0, err: ERR_NONE};
        if (mn.len > 3'd3) m[3] = '{value: mn.b[3], has: 1'b1, done: 1'b0, err: ERR_NONE};
        main_n = mn.len;
      end
      default: main_n = '0;
    endcase
  end

  always_comb begin
    ent = '0;
    if (emit_fl) begin
      ent[0] = '{value: fl.b[0], has: 1'b1, done: 1'b0, err: ERR_NONE};
      ent[1] = '{value: fl.b[1], has: 1'b1, done: 1'b0, err: ERR_NONE};
      ent[2] = '{value: fl.b[2], has: 1'b1, done: 1'b0, err: ERR_NONE};
      ent[3] = m[0];
      ent[4] = m[1];
      ent[5] = m[2];
    end else begin
      ent[0] = m[0];
      ent[1] = m[1];
      ent[2] = m[2];
      ent[3] = m[3];
    end
  end

  assign st_next    = nx;
  assign run.ent    = ent;
  assign run.n      = main_n + (emit_fl ? 3'd3 : 3'd0);
  assign run.closes = (kind == K_DONE);

endmodule
`default_nettype wire

// ===== rtl/json_string_unescape_utf8.sv =====
// JSON string body decoder: takes the bytes that follow an opening quote, one request per
// byte (or a source-end marker), resolves the simple escapes and \u escapes, joins a high
// surrogate with a following \u low surrogate, and sends the text out as UTF-8, one byte
// per result request; a closing quote or an error sends a result with string_done set and
// error_code (1 unterminated, 2 truncated escape, 3 unknown escape, 4 truncated \u,
// 5 bad hex digit), and the decoder is then at the start of a new string. Each input byte
// is decoded into a result buffer of up to six entries, which drains one result per cycle
// while the sink is ready; the input is held back while more than one of its results is
// left; the next byte is accepted in the cycle its predecessor's last result is taken.
`default_nettype none
`include "json_string_unescape_utf8_defines.svh"
module json_string_unescape_utf8 (
  input wire logic clk,
  input wire logic rst,
  jsu_stream_if.sink   in_ch,
  jsu_stream_if.source out_ch
);
  import jsu_pkg::*;

  state_t     st;
  state_t     st_next;
  run_t       run;
  ent_list_t  ents;
  logic [2:0] run_n;
  logic       in_fire;
  logic       out_fire;
  in_item_t   req;

  assign req = in_ch.data;

  jsu_decode u_decode (
    .st         (st),
    .in_byte    (req.in_byte),
    .source_end (req.source_end),
    .st_next    (st_next),
    .run        (run)
  );

  assign in_ch.ready = (run_n == 3'd0) || (run_n == 3'd1 && out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= '0;
      run_n <= '0;
    end else if (in_fire) begin
      st    <= st_next;
      run_n <= run.n;
    end else if (out_fire) begin
      run_n <= run_n - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ents <= run.ent;
    end else if (out_fire) begin
      ents <= {entry_t'('0), ents[RUN_MAX-1:1]};
    end
  end

  assign out_ch.valid = (run_n != 3'd0);
  assign out_ch.data  = '{out_byte:    ents[0].value,
                          has_byte:    ents[0].has,
                          string_done: ents[0].done,
                          error_code:  ents[0].err,
                          run_last:    (run_n == 3'd1)};

  `JSU_ASSERT_NEXT(a_close_clears, clk, rst, in_fire && run.closes, st == '0)
  `JSU_ASSERT_NOW(a_held_mode, clk, rst, st.held,
                  st.mode == M_HIGH || st.mode == M_HIGH_ESC || st.mode == M_HEX2)
  `JSU_ASSERT_NOW(a_done_is_last, clk, rst, out_ch.valid && ents[0].done, run_n == 3'd1)

endmodule
`default_nettype wire

// ===== dv/json_string_unescape_utf8_test.sv =====
module json_string_unescape_utf8_test;
  import jsu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LEN = 300;
  localparam int RANDOM_ITEMS = 500;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_Q      = 8'h71;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;

  localparam logic [7:0] SIMPLE_ESC [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_N,
                                            CH_T, CH_R, CH_B, CH_F};

  class unescape_scoreboard;
    mode_t       mode;
    logic [15:0] acc;
    logic [1:0]  digits;
    logic [9:0]  high;
    logic        held;
    out_item_t   expected_out[$];
    out_item_t   burst[$];
    int          errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      mode   = M_PLAIN;
      acc    = '0;
      digits = '0;
      high   = '0;
      held   = 1'b0;
    endfunction

    function void put(logic [7:0] value, logic has, logic done, logic [2:0] err);
      out_item_t r;
      r.out_byte    = value;
      r.has_byte    = has;
      r.string_done = done;
      r.error_code  = err;
      r.run_last    = 1'b0;
      burst = {burst, r};
    endfunction

    function void put_code_point(logic [20:0] cp);
      if (cp < 21'h80) begin
        put(cp[7:0], 1'b1, 1'b0, ERR_NONE);
      end else if (cp < 21'h800) begin
        put(8'hC0 | 8'(cp >> 6), 1'b1, 1'b0, ERR_NONE);
        put(8'h80 | 8'(cp & 21'h3F), 1'b1, 1'b0, ERR_NONE);
      end else if (cp < 21'h10000) begin
        put(8'hE0 | 8'(cp >> 12), 1'b1, 1'b0, ERR_NONE);
        put(8'h80 | 8'((cp >> 6) & 21'h3F), 1'b1, 1'b0, ERR_NONE);
        put(8'h80 | 8'(cp & 21'h3F), 1'b1, 1'b0, ERR_NONE);
      end else begin
        put(8'hF0 | 8'((cp >> 18) & 21'h07), 1'b1, 1'b0, ERR_NONE);
        put(8'h80 | 8'((cp >> 12) & 21'h3F), 1'b1, 1'b0, ERR_NONE);
        put(8'h80 | 8'((cp >> 6) & 21'h3F), 1'b1, 1'b0, ERR_NONE);
        put(8'h80 | 8'(cp & 21'h3F), 1'b1, 1'b0, ERR_NONE);
      end
    endfunction

    function void flush_high();
      if (held) put_code_point(21'(HIGH_FIRST) + 21'(high));
      held = 1'b0;
      high = '0;
    endfunction

    function void fail(logic [2:0] err);
      clear();
      put(8'h00, 1'b0, 1'b1, err);
    endfunction

    function void plain_byte(logic [7:0] b);
      if (b == CH_QUOTE) begin
        clear();
        put(8'h00, 1'b0, 1'b1, ERR_NONE);
      end else if (b == CH_BSLASH) begin
        mode = M_ESC;
      end else begin
        mode = M_PLAIN;
        put(b, 1'b1, 1'b0, ERR_NONE);
      end
    endfunction

    function void escape_char(logic [7:0] e);
      logic [7:0] v;
      case (e)
        CH_QUOTE:  v = CH_QUOTE;
        CH_BSLASH: v = CH_BSLASH;
        CH_SLASH:  v = CH_SLASH;
        CH_N:      v = 8'h0A;
        CH_T:      v = 8'h09;
        CH_R:      v = 8'h0D;
        CH_B:      v = 8'h08;
        CH_F:      v = 8'h0C;
        CH_U: begin
          mode   = M_HEX;
          acc    = '0;
          digits = '0;
          return;
        end
        default: begin
          fail(ERR_UNKNOWN_ESC);
          return;
        end
      endcase
      mode = M_PLAIN;
      put(v, 1'b1, 1'b0, ERR_NONE);
    endfunction

    function void fresh_unicode(logic [15:0] cp);
      if (cp >= HIGH_FIRST && cp <= HIGH_LAST) begin
        high = 10'(cp - HIGH_FIRST);
        held = 1'b1;
        mode = M_HIGH;
      end else begin
        mode = M_PLAIN;
        put_code_point(21'(cp));
      end
    endfunction

    function logic [4:0] hex_value(logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return 5'(c - CH_0);
      if (c >= CH_LA && c <= CH_LF) return 5'(c - CH_LA + 8'd10);
      if (c >= CH_UA && c <= CH_UF) return 5'(c - CH_UA + 8'd10);
      return 5'd16;
    endfunction

    function void predict_request(in_item_t it);
      mode_t       m;
      logic [4:0]  d;
      logic [15:0] cp;
      logic [20:0] full;
      burst.delete();
      m = mode;
      if (it.source_end) begin
        case (m)
          M_ESC:        fail(ERR_TRUNC_ESC);
          M_HEX, M_HEX2: fail(ERR_TRUNC_UNI);
          M_HIGH: begin
            flush_high();
            fail(ERR_UNTERMINATED);
          end
          M_HIGH_ESC: begin
            flush_high();
            fail(ERR_TRUNC_ESC);
          end
          default:      fail(ERR_UNTERMINATED);
        endcase
      end else begin
        case (m)
          M_ESC: escape_char(it.in_byte);
          M_HEX, M_HEX2: begin
            d = hex_value(it.in_byte);
            if (d[4]) begin
              fail(ERR_BAD_HEX);
            end else begin
              acc    = {acc[11:0], d[3:0]};
              digits = digits + 2'd1;
              if (digits == 2'd0) begin
                cp  = acc;
                acc = '0;
                if (m == M_HEX) begin
                  fresh_unicode(cp);
                end else if (cp >= LOW_FIRST && cp <= LOW_LAST) begin
                  full = 21'h10000 + {1'b0, high, 10'b0} + 21'(cp - LOW_FIRST);
                  held = 1'b0;
                  high = '0;
                  mode = M_PLAIN;
                  put_code_point(full);
                end else begin
                  flush_high();
                  fresh_unicode(cp);
                end
              end
            end
          end
          M_HIGH: begin
            if (it.in_byte == CH_BSLASH) begin
              mode = M_HIGH_ESC;
            end else begin
              flush_high();
              plain_byte(it.in_byte);
            end
          end
          M_HIGH_ESC: begin
            if (it.in_byte == CH_U) begin
              mode   = M_HEX2;
              acc    = '0;
              digits = '0;
            end else begin
              flush_high();
              escape_char(it.in_byte);
            end
          end
          default: plain_byte(it.in_byte);
        endcase
      end
      if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
      expected_out = {expected_out, burst};
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_output_byte(out_item_t got);
      out_item_t want;
      if (expected_out.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %0h has %0b done %0b err %0d",
                 $time, got.out_byte, got.has_byte, got.string_done, got.error_code);
        errors++;
        return;
      end
      want = expected_out.pop_front();
      check_field("out_byte", want.out_byte, got.out_byte);
      check_field("has_byte", want.has_byte, got.has_byte);
      check_field("string_done", want.string_done, got.string_done);
      check_field("error_code", want.error_code, got.error_code);
      check_field("run_last", want.run_last, got.run_last);
    endfunction
  endclass

  logic clk;
  logic rst;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   stall_cycles;
  int   items_sent;

  unescape_scoreboard sb;

  jsu_stream_if #(.T(in_item_t))  in_ch ();
  jsu_stream_if #(.T(out_item_t)) out_ch ();

  json_string_unescape_utf8 u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk) begin
    if (stall_cycles > 0) begin
      out_ch.ready <= 1'b0;
      stall_cycles--;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.predict_request(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_output_byte(out_ch.data);
    end
  end

  task automatic send_request(logic [7:0] b, logic e);
    int       gap;
    in_item_t it;
    gap = 0;
    while ($urandom_range(99, 0) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    it.in_byte    = b;
    it.source_end = e;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.expected_out.size() > 0);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return CH_0 + 8'(n);
    return ($urandom_range(1, 0) ? CH_LA : CH_UA) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] unknown_escape();
    logic [7:0] b;
    logic       known;
    do begin
      b = 8'($urandom);
      known = (b == CH_U);
      foreach (SIMPLE_ESC[i]) if (b == SIMPLE_ESC[i]) known = 1'b1;
    end while (known);
    return b;
  endfunction

  task automatic send_unicode(logic [15:0] v);
    send_request(CH_BSLASH, 1'b0);
    send_request(CH_U, 1'b0);
    for (int i = 3; i >= 0; i--) send_request(hex_char(v[4*i +: 4]), 1'b0);
  endtask

  // cut a \u escape short: bad digit or end of source after k digits
  task automatic send_partial_unicode(int k, bit bad_digit);
    logic [7:0] b;
    logic [4:0] d;
    send_request(CH_BSLASH, 1'b0);
    send_request(CH_U, 1'b0);
    repeat (k) send_request(hex_char(4'($urandom)), 1'b0);
    if (bad_digit) begin
      do begin
        b = 8'($urandom);
        d = sb.hex_value(b);
      end while (!d[4]);
      send_request(b, 1'b0);
    end else begin
      send_request(8'($urandom), 1'b1);
    end
  endtask

  function automatic logic [15:0] high_half();
    return 16'($urandom_range(HIGH_LAST, HIGH_FIRST));
  endfunction

  function automatic logic [15:0] low_half();
    return 16'($urandom_range(LOW_LAST, LOW_FIRST));
  endfunction

  task automatic send_random_string();
    int pick;
    repeat ($urandom_range(12, 0)) begin
      pick = $urandom_range(99, 0);
      if (pick < 38) begin
        send_request(plain_char(), 1'b0);
      end else if (pick < 53) begin
        send_request(CH_BSLASH, 1'b0);
        send_request(SIMPLE_ESC[$urandom_range(7, 0)], 1'b0);
      end else if (pick < 65) begin
        send_unicode(16'($urandom));
      end else if (pick < 77) begin
        send_unicode(high_half());
        send_unicode(low_half());
      end else if (pick < 85) begin
        send_unicode(high_half());
        case ($urandom_range(3, 0))
          0: send_request(plain_char(), 1'b0);
          1: begin
            send_request(CH_BSLASH, 1'b0);
            send_request(SIMPLE_ESC[$urandom_range(7, 0)], 1'b0);
          end
          2: send_unicode(high_half());
          default: send_unicode(16'($urandom));
        endcase
      end else if (pick < 91) begin
        send_unicode(16'($urandom_range(16'h07FF, 16'h0000)));
      end else if (pick < 96) begin
        send_unicode(low_half());
      end else begin
        send_request(8'($urandom), 1'b0);
      end
    end
    if ($urandom_range(99, 0) < 75) begin
      send_request(CH_QUOTE, 1'b0);
    end else begin
      case ($urandom_range(5, 0))
        0: send_request(8'($urandom), 1'b1);
        1: begin
          send_request(CH_BSLASH, 1'b0);
          send_request(unknown_escape(), 1'b0);
        end
        2: begin
          send_request(CH_BSLASH, 1'b0);
          send_request(8'($urandom), 1'b1);
        end
        3: send_partial_unicode($urandom_range(3, 0), 1'b1);
        4: send_partial_unicode($urandom_range(3, 0), 1'b0);
        default: begin
          send_unicode(high_half());
          case ($urandom_range(4, 0))
            0: send_request(8'($urandom), 1'b1);
            1: begin
              send_request(CH_BSLASH, 1'b0);
              send_request(8'($urandom), 1'b1);
            end
            2: begin
              send_request(CH_BSLASH, 1'b0);
              send_request(unknown_escape(), 1'b0);
            end
            3: send_partial_unicode($urandom_range(3, 0), 1'b0);
            default: send_partial_unicode($urandom_range(3, 0), 1'b1);
          endcase
        end
      endcase
    end
  endtask

  initial begin
    int base;
    sb            = new();
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    out_ch.ready  = 1'b0;
    stall_cycles  = 0;
    items_sent    = 0;
    src_idle_pct  = 6;
    sink_idle_pct = 67;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(CH_QUOTE, 1'b0);
    send_request(CH_BSLASH, 1'b0);
    send_request(CH_Q, 1'b0);
    send_unicode(HIGH_LAST);
    send_request(CH_BSLASH, 1'b0);
    send_request(CH_T, 1'b0);
    send_request(8'h00, 1'b1);
    send_unicode(HIGH_FIRST);
    send_request(8'hFF, 1'b1);
    send_request(CH_BSLASH, 1'b0);
    send_request(8'h00, 1'b1);
    send_partial_unicode(1, 1'b1);
    send_partial_unicode(1, 1'b0);

    base = items_sent;
    while (items_sent < base + RANDOM_ITEMS / 3) send_random_string();

    // hold the output long enough to back the input up
    stall_cycles = STALL_LEN;
    repeat (3) send_random_string();
    wait_drained();

    src_idle_pct  = 67;
    sink_idle_pct = 6;
    while (items_sent < base + 2 * RANDOM_ITEMS / 3) send_random_string();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    while (items_sent < base + RANDOM_ITEMS) send_random_string();

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.expected_out.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.expected_out.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
